// ===== rtl/core/mct_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI chord note tracker: shared package
// Types, codes and constants used by the sequencer, the output stage and
// the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package mct_pkg;

  localparam int NOTE_SLOTS = 8;   // note fields carried by one request
  localparam int IDX_W      = 3;   // index over the request's note fields
  localparam int NOTE_W     = 9;   // raw note field width
  localparam int PITCH_W    = 7;
  localparam int VEL_W      = 7;
  localparam int TIME_W     = 16;
  localparam int CHAN_W     = 5;
  localparam int CNT_W      = 4;
  localparam int LEAD_W     = 8;

  localparam logic [LEAD_W-1:0] LEAD_NONE = 8'hFF;
  localparam logic [CHAN_W-1:0] CHAN_MIN  = 5'd1;
  localparam logic [CHAN_W-1:0] CHAN_MAX  = 5'd16;
  localparam logic [VEL_W-1:0]  VEL_MIN   = 7'd1;
  localparam logic [VEL_W-1:0]  VEL_MAX   = 7'd127;

  typedef enum logic [1:0] {
    OP_SINGLE  = 2'd0,
    OP_CHORD   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_STATUS  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_OFF    = 2'd0,
    KIND_ON     = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OFF,
    ST_ON,
    ST_STAT
  } state_t;

  typedef logic [NOTE_W-1:0] note_raw_t;

  // Decoded input request
  typedef struct packed {
    op_t                          op;
    logic [CNT_W-1:0]             count;
    logic [VEL_W-1:0]             vel;
    logic [TIME_W-1:0]            time_pos;
    note_raw_t [NOTE_SLOTS-1:0]   notes;
  } req_t;

  // One result event
  typedef struct packed {
    kind_t                kind;
    logic [CHAN_W-1:0]    channel;
    logic [PITCH_W-1:0]   note;
    logic [VEL_W-1:0]     vel;
    logic [TIME_W-1:0]    time_pos;
    logic                 last;
    logic [CNT_W-1:0]     held_count;
    logic [LEAD_W-1:0]    lead;
  } evt_t;

endpackage

`default_nettype wire

// ===== rtl/core/mct_out.sv =====
// ----------------------------------------------------------------------------
// MIDI chord note tracker: output register
// Holds one event for the master side and packs it onto the stream bus.
// ----------------------------------------------------------------------------
`default_nettype none

module mct_out (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire mct_pkg::evt_t evt,
  output logic               slot_free,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // channel[4:0], note_number[11:5], event_velocity[18:12], event_time[34:19],
  // held_count[38:35], lead_note[46:39], zero[47]
  output logic [47:0]        m_axis_tdata,
  // kind[1:0]
  output logic [1:0]         m_axis_tuser,
  output logic               m_axis_tlast
);

  mct_pkg::evt_t held_evt;
  logic          valid;

  assign slot_free = !valid || m_axis_tready;

  // Hold the valid flag until the event is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (m_axis_tready) begin
      valid <= 1'b0;
    end
  end

  // Load a new event whenever the sequencer pushes one
  always_ff @(posedge clk) begin
    if (push) begin
      held_evt <= evt;
    end
  end

  assign m_axis_tvalid = valid;
  assign m_axis_tuser  = held_evt.kind;
  assign m_axis_tlast  = held_evt.last;
  assign m_axis_tdata  = {1'b0, held_evt.lead, held_evt.held_count, held_evt.time_pos,
                          held_evt.vel, held_evt.note, held_evt.channel};

endmodule

`default_nettype wire

// ===== rtl/core/mct_seq.sv =====
// ----------------------------------------------------------------------------
// MIDI chord note tracker: sequencer
// Walks request notes and held-note store one entry a cycle, bar output stalls,
// with a single comparator: a scan pass, then note-offs, then note-ons.
// ----------------------------------------------------------------------------
`default_nettype none

module mct_seq #(
  parameter int MAX_NOTES = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire mct_pkg::req_t               req,
  input  wire logic [mct_pkg::CHAN_W-1:0]  channel,
  input  wire logic                        slot_free,
  output logic                             push,
  output mct_pkg::evt_t                    evt
);

  localparam int IW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int CW = $clog2(MAX_NOTES + 1);

  mct_pkg::state_t state, state_next;

  // Latched request
  mct_pkg::note_raw_t [mct_pkg::NOTE_SLOTS-1:0] notes;
  logic [mct_pkg::VEL_W-1:0]          vel;
  logic [mct_pkg::TIME_W-1:0]         time_pos;
  logic [mct_pkg::IDX_W-1:0]          last_idx;

  // Scan results
  logic                               same;
  logic [CW-1:0]                      fin_cnt;
  logic [mct_pkg::PITCH_W-1:0]        fin_lead;
  logic [mct_pkg::IDX_W-1:0]          last_on;

  // Held-note store
  logic [mct_pkg::PITCH_W-1:0]        store [MAX_NOTES];
  logic [CW-1:0]                      held_total;
  logic [mct_pkg::PITCH_W-1:0]        lead_reg;

  logic [mct_pkg::IDX_W-1:0]          idx;

  // Shared datapath signals
  mct_pkg::note_raw_t                 cur_note;
  logic                               cur_ok;
  logic [mct_pkg::PITCH_W-1:0]        store_rd;
  logic                               match;
  logic                               at_end;
  logic                               off_last;
  logic [mct_pkg::CNT_W-1:0]          cnt_sat;
  logic                               load;
  logic                               scan_step;
  logic                               same_next;
  logic [CW-1:0]                      fin_cnt_next;
  logic                               idx_clr;
  logic                               idx_inc;
  logic                               held_clr;
  logic                               note_wr;

  assign cur_note = notes[idx];
  assign cur_ok   = (cur_note[mct_pkg::NOTE_W-1:mct_pkg::PITCH_W] == '0);
  assign store_rd = store[idx[IW-1:0]];
  assign match    = ({2'b00, store_rd} == cur_note);
  assign at_end   = (idx == last_idx);
  assign off_last = ((mct_pkg::CNT_W'(idx) + 4'd1) == mct_pkg::CNT_W'(held_total));

  assign cnt_sat  = (req.count > mct_pkg::CNT_W'(MAX_NOTES)) ?
                    mct_pkg::CNT_W'(MAX_NOTES) : req.count;

  assign same_next    = same && match;
  assign fin_cnt_next = cur_ok ? fin_cnt + CW'(1) : fin_cnt;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mct_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, strobes and the outgoing event
  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    push           = 1'b0;
    load           = 1'b0;
    scan_step      = 1'b0;
    idx_clr        = 1'b0;
    idx_inc        = 1'b0;
    held_clr       = 1'b0;
    note_wr        = 1'b0;
    evt.kind       = mct_pkg::KIND_OFF;
    evt.channel    = channel;
    evt.note       = store_rd;
    evt.vel        = '0;
    evt.time_pos   = time_pos;
    evt.last       = 1'b0;
    evt.held_count = mct_pkg::CNT_W'(fin_cnt);
    evt.lead       = (fin_cnt != '0) ? {1'b0, fin_lead} : mct_pkg::LEAD_NONE;

    case (state)
      mct_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          load = 1'b1;
          case (req.op)
            mct_pkg::OP_SINGLE: begin
              if (req.notes[0][mct_pkg::NOTE_W-1:mct_pkg::PITCH_W] == '0) begin
                state_next = mct_pkg::ST_SCAN;
              end
            end
            mct_pkg::OP_CHORD: begin
              if (cnt_sat != '0) begin
                state_next = mct_pkg::ST_SCAN;
              end
            end
            mct_pkg::OP_RELEASE: begin
              if (held_total != '0) begin
                state_next = mct_pkg::ST_OFF;
              end
            end
            mct_pkg::OP_STATUS: begin
              state_next = mct_pkg::ST_STAT;
            end
            default: begin
              state_next = mct_pkg::ST_IDLE;
            end
          endcase
        end
      end

      // Compare one note a cycle against the store, count the valid ones
      mct_pkg::ST_SCAN: begin
        scan_step = 1'b1;
        if (at_end) begin
          idx_clr = 1'b1;
          if (same_next) begin
            state_next = mct_pkg::ST_IDLE;
          end else if (held_total != '0) begin
            state_next = mct_pkg::ST_OFF;
          end else if (fin_cnt_next != '0) begin
            state_next = mct_pkg::ST_ON;
          end else begin
            state_next = mct_pkg::ST_IDLE;
          end
        end else begin
          idx_inc = 1'b1;
        end
      end

      // Release the held notes in store order
      mct_pkg::ST_OFF: begin
        evt.last = off_last && (fin_cnt == '0);
        if (slot_free) begin
          push = 1'b1;
          if (off_last) begin
            idx_clr  = 1'b1;
            held_clr = 1'b1;
            state_next = (fin_cnt != '0) ? mct_pkg::ST_ON : mct_pkg::ST_IDLE;
          end else begin
            idx_inc = 1'b1;
          end
        end
      end

      // Emit and keep the valid new notes, skip the others
      mct_pkg::ST_ON: begin
        evt.kind = mct_pkg::KIND_ON;
        evt.note = cur_note[mct_pkg::PITCH_W-1:0];
        evt.vel  = vel;
        evt.last = (idx == last_on);
        if (!cur_ok || slot_free) begin
          push    = cur_ok;
          note_wr = cur_ok;
          if (at_end) begin
            idx_clr    = 1'b1;
            state_next = mct_pkg::ST_IDLE;
          end else begin
            idx_inc = 1'b1;
          end
        end
      end

      mct_pkg::ST_STAT: begin
        evt.kind       = mct_pkg::KIND_STATUS;
        evt.note       = '0;
        evt.last       = 1'b1;
        evt.held_count = mct_pkg::CNT_W'(held_total);
        evt.lead       = (held_total != '0) ? {1'b0, lead_reg} : mct_pkg::LEAD_NONE;
        if (slot_free) begin
          push       = 1'b1;
          state_next = mct_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = mct_pkg::ST_IDLE;
      end
    endcase
  end

  // Latch the request and advance the scan
  always_ff @(posedge clk) begin
    if (load) begin
      notes    <= req.notes;
      vel      <= req.vel;
      time_pos <= req.time_pos;
      fin_cnt  <= '0;
      if (req.op == mct_pkg::OP_SINGLE) begin
        last_idx <= '0;
        same     <= (held_total == CW'(1));
      end else begin
        last_idx <= mct_pkg::IDX_W'(cnt_sat - 4'd1);
        same     <= (mct_pkg::CNT_W'(held_total) == cnt_sat);
      end
    end else if (scan_step) begin
      same    <= same_next;
      fin_cnt <= fin_cnt_next;
      if (cur_ok) begin
        last_on <= idx;
        if (fin_cnt == '0) begin
          fin_lead <= cur_note[mct_pkg::PITCH_W-1:0];
        end
      end
    end
  end

  // Step the shared index
  always_ff @(posedge clk) begin
    if (rst || load || idx_clr) begin
      idx <= '0;
    end else if (idx_inc) begin
      idx <= idx + mct_pkg::IDX_W'(1);
    end
  end

  // Track the number of held notes
  always_ff @(posedge clk) begin
    if (rst || held_clr) begin
      held_total <= '0;
    end else if (note_wr) begin
      held_total <= held_total + CW'(1);
    end
  end

  // Write new notes into the store and keep the first one at hand
  always_ff @(posedge clk) begin
    if (note_wr) begin
      store[held_total[IW-1:0]] <= cur_note[mct_pkg::PITCH_W-1:0];
      if (held_total == '0) begin
        lead_reg <= cur_note[mct_pkg::PITCH_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/midi_chord_note_tracker.sv =====
// ----------------------------------------------------------------------------
// MIDI chord note tracker
// Tracks the sounding notes and turns note, chord, release and status
// requests into note-on, note-off and status events.
// ----------------------------------------------------------------------------
// One request is taken at a time; s_axis_tready is high only while the block
// is idle. After a request is accepted, a single note or a chord of N notes
// (N capped at MAX_NOTES) goes through a scan pass over the N notes, a release
// pass over each held note and a note-on pass over the N notes. Release-all runs
// only the release pass and a status query emits one status event. The single
// comparator and the one read port of the held-note store are stepped over
// one note per cycle, pausing in the release and note-on passes while the
// output register is busy. Events are held in an output register, so a stalled
// master side only pauses the sequencer. No clearing pass is needed after
// reset. The channel register may be written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_chord_note_tracker #(
  parameter int MAX_NOTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [4:0]  cfg_wr_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // note_count[3:0], velocity[19:4], sample_position[35:20], note_0[44:36],
  // note_1[53:45], note_2[62:54], note_3[71:63], note_4[80:72],
  // note_5[89:81], note_6[98:90], note_7[107:99], zero[111:108]
  input  wire logic [111:0] s_axis_tdata,
  // operation[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // channel[4:0], note_number[11:5], event_velocity[18:12], event_time[34:19],
  // held_count[38:35], lead_note[46:39], zero[47]
  output logic [47:0]      m_axis_tdata,
  // kind[1:0]
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  logic [mct_pkg::CHAN_W-1:0] channel;
  logic [15:0]                vel_raw;
  mct_pkg::req_t              req;
  mct_pkg::evt_t              evt;
  logic                       push;
  logic                       slot_free;

  // Hold the channel register, saturated to 1..16
  always_ff @(posedge clk) begin
    if (rst) begin
      channel <= mct_pkg::CHAN_MIN;
    end else if (cfg_wr_en) begin
      if (cfg_wr_data < mct_pkg::CHAN_MIN) begin
        channel <= mct_pkg::CHAN_MIN;
      end else if (cfg_wr_data > mct_pkg::CHAN_MAX) begin
        channel <= mct_pkg::CHAN_MAX;
      end else begin
        channel <= cfg_wr_data;
      end
    end
  end

  assign vel_raw = s_axis_tdata[19:4];

  // Unpack the request and clamp the Q8.8 velocity to 1..127
  always_comb begin
    req.op       = mct_pkg::op_t'(s_axis_tuser);
    req.count    = s_axis_tdata[3:0];
    req.time_pos = s_axis_tdata[35:20];
    for (int i = 0; i < mct_pkg::NOTE_SLOTS; i++) begin
      req.notes[i] = s_axis_tdata[36 + mct_pkg::NOTE_W * i +: mct_pkg::NOTE_W];
    end
    if (vel_raw[15] || (vel_raw[14:8] == '0)) begin
      req.vel = mct_pkg::VEL_MIN;
    end else if (vel_raw[14:8] == mct_pkg::VEL_MAX) begin
      req.vel = mct_pkg::VEL_MAX;
    end else begin
      req.vel = vel_raw[14:8];
    end
  end

  mct_seq #(
    .MAX_NOTES (MAX_NOTES)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .req       (req),
    .channel   (channel),
    .slot_free (slot_free),
    .push      (push),
    .evt       (evt)
  );

  mct_out u_out (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .evt           (evt),
    .slot_free     (slot_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire
